// ===== rtl/uedw_pkg.sv =====
// Shared types and constants for the USB endpoint descriptor walker.
package uedw_pkg;

    localparam logic [7:0]  DESC_TYPE_ENDPOINT = 8'h05;
    localparam logic [7:0]  MIN_EP_LENGTH      = 8'd7;
    localparam logic [7:0]  MIN_DESC_LENGTH    = 8'd2;
    localparam logic [7:0]  POS_LENGTH         = 8'd0;
    localparam logic [7:0]  POS_TYPE           = 8'd1;
    localparam logic [7:0]  POS_ADDRESS        = 8'd2;
    localparam logic [7:0]  POS_ATTRIBUTES     = 8'd3;
    localparam logic [7:0]  POS_INTERVAL       = 8'd6;
    localparam logic [7:0]  COUNT_MAX          = 8'd255;
    localparam logic [9:0]  FRAME_US           = 10'd1000;
    localparam logic [21:0] HS_BASE_US         = 22'd125;
    localparam logic [7:0]  MAX_HS_EXP         = 8'd16;
    localparam int          ADDR_IN_BIT        = 7;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam int APB_AW = 3;
    localparam logic REG_IDX_SPEED = 1'b0;

    localparam int TDATA_OUT_W = 56;

    typedef enum logic
    {
        KIND_ENDPOINT = 1'b0,
        KIND_END      = 1'b1
    } record_kind_t;

    // One queue entry: what a single byte produced, endpoint and/or end of walk.
    typedef struct packed
    {
        logic       has_ep;
        logic [7:0] address;
        logic       iso;
        logic [7:0] interval;
        logic [7:0] count;
        logic       has_end;
        logic       malformed;
    } qentry_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } qstatus_t;

endpackage

// ===== rtl/uedw_front.sv =====
// Front part: walks the descriptor bytes and classifies what each byte completes.
module uedw_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  uedw_pkg::qstatus_t qstat,
    output logic              byte_ready,
    output logic              push,
    output uedw_pkg::qentry_t push_entry
);

    logic [7:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] attr_reg, attr_next;
    logic [7:0] intv_reg, intv_next;
    logic [7:0] count_reg, count_next;
    logic       halted_reg, halted_next;
    logic       malf_reg, malf_next;

    logic       accept;
    logic       halt_now;
    logic       complete;
    logic       match;
    logic [8:0] pos_plus;

    assign byte_ready = !qstat.full;
    assign accept     = byte_valid && byte_ready;

    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        addr_next   = addr_reg;
        attr_next   = attr_reg;
        intv_next   = intv_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        malf_next   = malf_reg;
        halt_now    = 1'b0;
        complete    = 1'b0;
        match       = 1'b0;
        pos_plus    = {1'b0, pos_reg} + 9'd1;

        if (!halted_reg)
        begin
            if (pos_reg == uedw_pkg::POS_LENGTH)
            begin
                len_next = data_byte;
                halt_now = (data_byte < uedw_pkg::MIN_DESC_LENGTH);
            end
            if (pos_reg == uedw_pkg::POS_TYPE)
            begin
                type_next = data_byte;
            end
            if (pos_reg == uedw_pkg::POS_ADDRESS)
            begin
                addr_next = data_byte;
            end
            if (pos_reg == uedw_pkg::POS_ATTRIBUTES)
            begin
                attr_next = data_byte;
            end
            if (pos_reg == uedw_pkg::POS_INTERVAL)
            begin
                intv_next = data_byte;
            end

            if (halt_now)
            begin
                halted_next = 1'b1;
                malf_next   = 1'b1;
            end
            else
            begin
                complete = (pos_plus >= {1'b0, len_next});
                pos_next = complete ? 8'd0 : pos_plus[7:0];
            end

            // Transfer type interrupt (3) or isochronous (1): attribute bit 0 set.
            match = complete && (type_next == uedw_pkg::DESC_TYPE_ENDPOINT) &&
                    (len_next >= uedw_pkg::MIN_EP_LENGTH) && attr_next[0];
            if (match && (count_reg != uedw_pkg::COUNT_MAX))
            begin
                count_next = count_reg + 8'd1;
            end
        end

        push_entry.has_ep    = match;
        push_entry.address   = addr_next;
        push_entry.iso       = !attr_next[1];
        push_entry.interval  = intv_next;
        push_entry.count     = count_next;
        push_entry.has_end   = last_byte;
        push_entry.malformed = malf_next || (!halted_next && (pos_next != 8'd0));

        push = accept && (match || last_byte);

        if (last_byte)
        begin
            pos_next    = 8'd0;
            len_next    = 8'd0;
            type_next   = 8'd0;
            addr_next   = 8'd0;
            attr_next   = 8'd0;
            intv_next   = 8'd0;
            count_next  = 8'd0;
            halted_next = 1'b0;
            malf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            type_reg   <= '0;
            addr_reg   <= '0;
            attr_reg   <= '0;
            intv_reg   <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
            malf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            addr_reg   <= addr_next;
            attr_reg   <= attr_next;
            intv_reg   <= intv_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
            malf_reg   <= malf_next;
        end
    end

endmodule

// ===== rtl/uedw_queue.sv =====
// Short queue that decouples the byte walker from the record emitter.
module uedw_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  uedw_pkg::qentry_t  push_entry,
    input  logic               pop,
    output uedw_pkg::qentry_t  head,
    output uedw_pkg::qstatus_t qstat
);

    uedw_pkg::qentry_t                 mem_reg [uedw_pkg::QDEPTH];
    logic [uedw_pkg::QAW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [uedw_pkg::QAW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [uedw_pkg::QAW:0]            count_reg, count_next;
    logic                              do_push;
    logic                              do_pop;

    assign qstat.full  = (count_reg == (uedw_pkg::QAW+1)'(uedw_pkg::QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/uedw_back.sv =====
// Back part: turns queue entries into endpoint and end records in an output register.
module uedw_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_based_speed,
    input  uedw_pkg::qentry_t  head,
    input  uedw_pkg::qstatus_t qstat,
    output logic               pop,
    input  logic               rec_ready,
    output logic               rec_valid,
    output logic               record_kind,
    output logic [7:0]         ep_address,
    output logic               is_in,
    output logic               xfer_type,
    output logic [7:0]         interval_raw,
    output logic [21:0]        poll_us,
    output logic               interval_clamped,
    output logic [7:0]         endpoints_found,
    output logic               malformed,
    output logic               last_result
);

    logic         valid_reg, valid_next;
    logic         ep_done_reg, ep_done_next;
    logic         load;
    logic         kind_reg, kind_next;
    logic [7:0]   addr_reg, addr_next;
    logic         in_reg, in_next;
    logic         xt_reg, xt_next;
    logic [7:0]   raw_reg, raw_next;
    logic [21:0]  us_reg, us_next;
    logic         clamp_reg, clamp_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic         malf_reg, malf_next;

    logic [17:0]  frame_us;
    logic [4:0]   hs_exp;
    logic [21:0]  ep_us;
    logic         ep_clamp;

    always_comb
    begin
        frame_us = 18'(head.interval) * 18'(uedw_pkg::FRAME_US);
        ep_clamp = 1'b0;
        hs_exp   = head.interval[4:0];
        if (head.interval > uedw_pkg::MAX_HS_EXP)
        begin
            ep_clamp = 1'b1;
            hs_exp   = uedw_pkg::MAX_HS_EXP[4:0];
        end
        if (head.interval == 8'd0)
        begin
            ep_us    = '0;
            ep_clamp = 1'b0;
        end
        else if (frame_based_speed)
        begin
            ep_us    = {4'd0, frame_us};
            ep_clamp = 1'b0;
        end
        else
        begin
            ep_us = uedw_pkg::HS_BASE_US << (hs_exp - 5'd1);
        end
    end

    always_comb
    begin
        load         = !valid_reg || rec_ready;
        pop          = 1'b0;
        valid_next   = valid_reg;
        ep_done_next = ep_done_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        in_next      = in_reg;
        xt_next      = xt_reg;
        raw_next     = raw_reg;
        us_next      = us_reg;
        clamp_next   = clamp_reg;
        cnt_next     = cnt_reg;
        malf_next    = malf_reg;

        if (load)
        begin
            valid_next = !qstat.empty;
            if (!qstat.empty)
            begin
                cnt_next = head.count;
                if (head.has_ep && !ep_done_reg)
                begin
                    kind_next  = uedw_pkg::KIND_ENDPOINT;
                    addr_next  = head.address;
                    in_next    = head.address[uedw_pkg::ADDR_IN_BIT];
                    xt_next    = head.iso;
                    raw_next   = head.interval;
                    us_next    = ep_us;
                    clamp_next = ep_clamp;
                    malf_next  = 1'b0;
                    if (head.has_end)
                    begin
                        ep_done_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    kind_next    = uedw_pkg::KIND_END;
                    addr_next    = '0;
                    in_next      = 1'b0;
                    xt_next      = 1'b0;
                    raw_next     = '0;
                    us_next      = '0;
                    clamp_next   = 1'b0;
                    malf_next    = head.malformed;
                    ep_done_next = 1'b0;
                    pop          = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            ep_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            ep_done_reg <= ep_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        addr_reg  <= addr_next;
        in_reg    <= in_next;
        xt_reg    <= xt_next;
        raw_reg   <= raw_next;
        us_reg    <= us_next;
        clamp_reg <= clamp_next;
        cnt_reg   <= cnt_next;
        malf_reg  <= malf_next;
    end

    assign rec_valid        = valid_reg;
    assign record_kind      = kind_reg;
    assign ep_address       = addr_reg;
    assign is_in            = in_reg;
    assign xfer_type        = xt_reg;
    assign interval_raw     = raw_reg;
    assign poll_us          = us_reg;
    assign interval_clamped = clamp_reg;
    assign endpoints_found  = cnt_reg;
    assign malformed        = malf_reg;
    assign last_result      = (kind_reg == uedw_pkg::KIND_END);

endmodule

// ===== rtl/usb_endpoint_descriptor_walker_top.sv =====
// Top level of the USB endpoint descriptor walker.
// The block takes one descriptor byte per cycle and never stalls the input while its
// four-entry queue has room. A record is loaded from the queue head into the output
// register when that register is empty or being read. A byte that completes a matching
// endpoint and also ends the blob yields two records, sent one after the other while the
// queue keeps taking entries. The register frame_based_speed, at address 0, must be
// written by the user only while the block is idle; the block does not enforce this.
module usb_endpoint_descriptor_walker_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [uedw_pkg::APB_AW-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] data_byte
    input  logic                            s_tlast,  // last_byte
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] ep_address, [8] is_in, [9] xfer_type, [17:10] interval_raw,
    // [39:18] poll_us, [40] interval_clamped, [48:41] endpoints_found,
    // [49] malformed, [55:50] zero
    output logic [uedw_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic                            m_tuser,  // record_kind
    output logic                            m_tlast   // last_result
);

    logic               speed_reg;
    logic               cfg_write;
    uedw_pkg::qentry_t  push_entry;
    uedw_pkg::qentry_t  head;
    uedw_pkg::qstatus_t qstat;
    logic               push;
    logic               pop;

    logic [7:0]  ep_address;
    logic        is_in;
    logic        xfer_type;
    logic [7:0]  interval_raw;
    logic [21:0] poll_us;
    logic        interval_clamped;
    logic [7:0]  endpoints_found;
    logic        malformed;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == uedw_pkg::REG_IDX_SPEED);
    assign prdata    = (paddr[2] == uedw_pkg::REG_IDX_SPEED) ? {31'd0, speed_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            speed_reg <= pwdata[0];
        end
    end

    uedw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .qstat      (qstat),
        .byte_ready (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    uedw_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    uedw_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame_based_speed (speed_reg),
        .head              (head),
        .qstat             (qstat),
        .pop               (pop),
        .rec_ready         (m_tready),
        .rec_valid         (m_tvalid),
        .record_kind       (m_tuser),
        .ep_address        (ep_address),
        .is_in             (is_in),
        .xfer_type         (xfer_type),
        .interval_raw      (interval_raw),
        .poll_us           (poll_us),
        .interval_clamped  (interval_clamped),
        .endpoints_found   (endpoints_found),
        .malformed         (malformed),
        .last_result       (m_tlast)
    );

    assign m_tdata = {6'd0, malformed, endpoints_found, interval_clamped, poll_us,
                      interval_raw, xfer_type, is_in, ep_address};

endmodule

// ===== rtl/uedw_checker.sv =====
// Port-level checker for the descriptor walker, bound to the top level.
module uedw_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [uedw_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic                             m_tuser,
    input logic                             m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("end flag and record kind disagree");

    a_ep_not_malformed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !m_tdata[49])
        else $error("endpoint record flagged malformed");

    a_end_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[40:0] == 41'd0))
        else $error("end record carries endpoint fields");

    a_clamp_needs_raw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && m_tdata[40] |-> (m_tdata[17:10] > 8'd16))
        else $error("clamp flag without an oversized interval");

endmodule

bind usb_endpoint_descriptor_walker_top uedw_checker u_uedw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
